FILE: sv/nrgt_pkg.sv
// shared types and constants for the nonce replay guard table
package nrgt_pkg;

   // reject cause codes as shown on the result channel
   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_EXPIRED = 2'd1,
      CAUSE_REPLAY  = 2'd2,
      CAUSE_FULL    = 2'd3
   } cause_type;

   // controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_issue;
      logic out_free;
   } status_type;

   localparam logic [31:0] TIMEOUT_RESET = 32'd300000;

endpackage

FILE: sv/nrgt_ctrl.sv
// controller state machine for the nonce replay guard table
module nrgt_ctrl
   import nrgt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/nrgt_datapath.sv
// table storage, scan evaluation and result register for the nonce replay guard
module nrgt_datapath
   import nrgt_pkg::*;
#(
   parameter int SESSION_ENTRIES = 16,
   parameter int KEY_BYTES       = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [63:0] req_key_word0,
   input  logic [63:0] req_key_word1,
   input  logic [63:0] req_key_word2,
   input  logic [63:0] req_key_word3,
   input  logic [31:0] req_use_count,
   input  logic [63:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_table_full,
   output logic [1:0]  rsp_reject_cause,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam int IDXW     = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
   localparam int KEY_BITS = 8 * KEY_BYTES;
   localparam logic [IDXW:0] LAST_ADDR = (IDXW + 1)'(SESSION_ENTRIES - 1);

   logic [255:0]          key_full;
   logic [31:0]           timeout_ff;
   logic [KEY_BITS-1:0]   key_q_ff;
   logic [31:0]           cnt_q_ff;
   logic [63:0]           now_q_ff;

   logic [IDXW:0]         addr_ff;
   logic                  rd_vld_ff;
   logic [IDXW-1:0]       rd_idx_ff;

   logic [KEY_BITS-1:0]   key_mem [SESSION_ENTRIES];
   logic [63:0]           ls_mem  [SESSION_ENTRIES];
   logic [31:0]           cnt_mem [SESSION_ENTRIES];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [63:0]           ls_rd_ff;
   logic [31:0]           cnt_rd_ff;

   logic [SESSION_ENTRIES-1:0] valid_ff, valid_in;
   logic [SESSION_ENTRIES-1:0] exp_vec_ff;
   logic                  hit_found_ff;
   logic [IDXW-1:0]       hit_idx_ff;
   logic                  hit_exp_ff;
   logic [31:0]           hit_cnt_ff;
   logic                  free_found_ff;
   logic [IDXW-1:0]       free_idx_ff;

   logic                  entry_v;
   logic [63:0]           elapsed;
   logic                  entry_exp;
   logic                  entry_match;

   logic                  acc_in;
   logic                  full_in;
   cause_type             cause_in;
   logic                  wr_key_en;
   logic                  wr_rec_en;
   logic [IDXW-1:0]       wr_idx;

   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff;
   logic                  rsp_full_ff;
   cause_type             rsp_cause_ff;

   // bytes beyond the key length drop out of the stored key
   assign key_full = {req_key_word3, req_key_word2, req_key_word1, req_key_word0};

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_wdata;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_q_ff <= key_full[KEY_BITS-1:0];
         cnt_q_ff <= req_use_count;
         now_q_ff <= req_time_now;
      end
   end

   // scan address and read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            addr_ff <= '0;
         end else if (cmd.scan) begin
            addr_ff <= addr_ff + 1'b1;
         end
         rd_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[IDXW-1:0];
   end

   assign status.last_issue = (addr_ff == LAST_ADDR);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         key_rd_ff <= key_mem[addr_ff[IDXW-1:0]];
         ls_rd_ff  <= ls_mem[addr_ff[IDXW-1:0]];
         cnt_rd_ff <= cnt_mem[addr_ff[IDXW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_idx] <= key_q_ff;
      end
      if (wr_rec_en) begin
         ls_mem[wr_idx]  <= now_q_ff;
         cnt_mem[wr_idx] <= cnt_q_ff;
      end
   end

   // per entry evaluation
   assign entry_v     = valid_ff[rd_idx_ff];
   assign elapsed     = now_q_ff - ls_rd_ff;
   assign entry_exp   = entry_v && (elapsed > {32'd0, timeout_ff});
   assign entry_match = entry_v && (key_rd_ff == key_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (entry_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
         end
         if ((!entry_v || entry_exp) && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         exp_vec_ff[rd_idx_ff] <= entry_exp;
         if (entry_match && !hit_found_ff) begin
            hit_idx_ff <= rd_idx_ff;
            hit_exp_ff <= entry_exp;
            hit_cnt_ff <= cnt_rd_ff;
         end
         if ((!entry_v || entry_exp) && !free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // decision and table update
   always_comb begin
      valid_in  = valid_ff;
      acc_in    = 1'b0;
      full_in   = 1'b0;
      cause_in  = CAUSE_NONE;
      wr_key_en = 1'b0;
      wr_rec_en = 1'b0;
      wr_idx    = hit_idx_ff;
      if (hit_found_ff) begin
         if (hit_exp_ff) begin
            valid_in[hit_idx_ff] = 1'b0;
            cause_in             = CAUSE_EXPIRED;
         end else if (cnt_q_ff > hit_cnt_ff) begin
            acc_in    = 1'b1;
            wr_rec_en = cmd.commit;
         end else begin
            cause_in = CAUSE_REPLAY;
         end
      end else begin
         // new nonce: expired entries go first
         valid_in = valid_ff & ~exp_vec_ff;
         wr_idx   = free_idx_ff;
         if (free_found_ff) begin
            valid_in[free_idx_ff] = 1'b1;
            acc_in                = 1'b1;
            wr_key_en             = cmd.commit;
            wr_rec_en             = cmd.commit;
         end else begin
            full_in  = 1'b1;
            cause_in = CAUSE_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_acc_ff   <= acc_in;
         rsp_full_ff  <= full_in;
         rsp_cause_ff <= cause_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_reject_cause = rsp_cause_ff;

endmodule

FILE: sv/nonce_replay_guard_table_top.sv
// top level of the nonce replay guard table
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   key words 0..3, use count, time now
//  rsp       out        rsp_valid / rsp_ready   accepted, table full, reject cause
//  csr       in         csr_valid / csr_ready   expiry timeout (32 bit)
//
// an item passes from acceptance to result in steps: the scan reads
// one table entry a cycle through the single memory read port, then a drain step
// and a commit step; the next item is taken only once the current one has committed
// reset clears the valid bits at once, so no clearing pass is needed
// the result sits in an output register; the next item is taken while it waits,
// and only the commit step stalls when rsp_ready stays low
// csr_ready is always high

module nonce_replay_guard_table_top
   import nrgt_pkg::*;
#(
   parameter int SESSION_ENTRIES = 16,
   parameter int KEY_BYTES       = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_key_word0,
   input  logic [63:0] req_key_word1,
   input  logic [63:0] req_key_word2,
   input  logic [63:0] req_key_word3,
   input  logic [31:0] req_use_count,
   input  logic [63:0] req_time_now,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_table_full,
   output logic [1:0]  rsp_reject_cause,
   // expiry timeout register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle, scan over the table, drain the read pipe, commit
   nrgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memories, valid bits, per entry compare and result register
   nrgt_datapath #(
      .SESSION_ENTRIES (SESSION_ENTRIES),
      .KEY_BYTES       (KEY_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_key_word0    (req_key_word0),
      .req_key_word1    (req_key_word1),
      .req_key_word2    (req_key_word2),
      .req_key_word3    (req_key_word3),
      .req_use_count    (req_use_count),
      .req_time_now     (req_time_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_table_full   (rsp_table_full),
      .rsp_reject_cause (rsp_reject_cause),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

endmodule

FILE: sv/nrgt_checker.sv
// port level checks for the nonce replay guard table, with bind
module nrgt_checker
   import nrgt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [63:0] req_key_word0,
   input logic [63:0] req_key_word1,
   input logic [63:0] req_key_word2,
   input logic [63:0] req_key_word3,
   input logic [31:0] req_use_count,
   input logic [63:0] req_time_now,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_table_full,
   input logic [1:0]  rsp_reject_cause,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [31:0] csr_wdata
);

   // an accepted item carries no cause and no full flag
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_table_full && rsp_reject_cause == CAUSE_NONE)
      else $error("accepted item with reject cause or full flag");

   // full flag goes with the full cause and nothing else
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_table_full == (rsp_reject_cause == CAUSE_FULL))
      else $error("table full flag and cause disagree");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_table_full) && $stable(rsp_reject_cause))
      else $error("result changed while stalled");

   // one item at a time: busy right after an item is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready straight after an accepted item");

endmodule

bind nonce_replay_guard_table_top nrgt_checker u_nrgt_checker (.*);

FILE: tb/testbench.sv
// self-checking testbench for the nonce replay guard table
`timescale 1ns / 1ps

module testbench;
   import nrgt_pkg::*;

   localparam int SESSION_ENTRIES = 16;
   localparam int KEY_BYTES       = 32;
   localparam int KEY_WORDS       = 4;
   // nonces in the stimulus pool, more than the table holds so that it fills
   localparam int POOL            = 22;
   localparam int PHASE_ITEMS     = 122;
   // cycles with no handshake at all before the run is called hung
   localparam int QUIET_LIMIT     = 4000;

   // one expected result item
   typedef struct {
      logic      accepted;
      logic      table_full;
      cause_type cause;
   } verdict_type;

   // model of the nonce table plus the queue of verdicts still owed by the block
   class guard_board;
      logic [31:0] expiry_limit;
      bit          ent_valid [SESSION_ENTRIES];
      logic [63:0] ent_key   [SESSION_ENTRIES][KEY_WORDS];
      logic [63:0] ent_seen  [SESSION_ENTRIES];
      logic [31:0] ent_count [SESSION_ENTRIES];
      verdict_type due_verdicts [$];
      int          failures;

      function new();
         expiry_limit = TIMEOUT_RESET;
         failures     = 0;
         foreach (ent_valid[e]) ent_valid[e] = 1'b0;
      endfunction

      function void set_timeout(logic [31:0] value);
         expiry_limit = value;
      endfunction

      function logic [63:0] word_mask(int w);
         int n;
         n = KEY_BYTES - 8 * w;
         if (n >= 8) return '1;
         if (n <= 0) return '0;
         return (64'd1 << (8 * n)) - 64'd1;
      endfunction

      function bit stale(int e, logic [63:0] now);
         logic [63:0] elapsed;
         elapsed = now - ent_seen[e];
         return elapsed > {32'd0, expiry_limit};
      endfunction

      // works out the verdict for an accepted request item and updates the table
      function void admit_request(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                  logic [63:0] w3, logic [31:0] cnt, logic [63:0] now);
         logic [63:0] key [KEY_WORDS];
         int          hit;
         int          slot;
         bit          same;
         verdict_type v;
         key[0] = w0 & word_mask(0);
         key[1] = w1 & word_mask(1);
         key[2] = w2 & word_mask(2);
         key[3] = w3 & word_mask(3);
         v.accepted   = 1'b0;
         v.table_full = 1'b0;
         v.cause      = CAUSE_NONE;
         hit = -1;
         for (int e = 0; e < SESSION_ENTRIES && hit < 0; e++) begin
            same = ent_valid[e];
            for (int w = 0; w < KEY_WORDS; w++)
               if (ent_key[e][w] != key[w]) same = 1'b0;
            if (same) hit = e;
         end
         if (hit < 0) begin
            // unknown nonce: sweep out expired entries, then take the lowest free one
            for (int e = 0; e < SESSION_ENTRIES; e++)
               if (ent_valid[e] && stale(e, now)) ent_valid[e] = 1'b0;
            slot = -1;
            for (int e = SESSION_ENTRIES - 1; e >= 0; e--)
               if (!ent_valid[e]) slot = e;
            if (slot < 0) begin
               v.table_full = 1'b1;
               v.cause      = CAUSE_FULL;
            end else begin
               ent_valid[slot] = 1'b1;
               for (int w = 0; w < KEY_WORDS; w++) ent_key[slot][w] = key[w];
               ent_seen[slot]  = now;
               ent_count[slot] = cnt;
               v.accepted      = 1'b1;
            end
         end else if (stale(hit, now)) begin
            ent_valid[hit] = 1'b0;
            v.cause        = CAUSE_EXPIRED;
         end else if (cnt > ent_count[hit]) begin
            ent_seen[hit]  = now;
            ent_count[hit] = cnt;
            v.accepted     = 1'b1;
         end else begin
            v.cause = CAUSE_REPLAY;
         end
         due_verdicts.push_back(v);
      endfunction

      function void check_verdict(logic acc, logic full, logic [1:0] cause);
         verdict_type v;
         if (due_verdicts.size() == 0) begin
            $error("result item with no request outstanding: accepted %0b table_full %0b cause %0d",
                   acc, full, cause);
            failures++;
            return;
         end
         v = due_verdicts.pop_front();
         if (acc !== v.accepted) begin
            $error("accepted: expected %0b, got %0b", v.accepted, acc);
            failures++;
         end
         if (full !== v.table_full) begin
            $error("table_full: expected %0b, got %0b", v.table_full, full);
            failures++;
         end
         if (cause !== v.cause) begin
            $error("reject_cause: expected %0d, got %0d", v.cause, cause);
            failures++;
         end
      endfunction

      function int outstanding();
         return due_verdicts.size();
      endfunction

      function void report_leftover();
         if (due_verdicts.size() != 0) begin
            $error("%0d result items never arrived", due_verdicts.size());
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_key_word0;
   logic [63:0] req_key_word1;
   logic [63:0] req_key_word2;
   logic [63:0] req_key_word3;
   logic [31:0] req_use_count;
   logic [63:0] req_time_now;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic        rsp_table_full;
   logic [1:0]  rsp_reject_cause;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_wdata;

   guard_board  board;

   // stimulus side bookkeeping: a rough view of each pool nonce, only used to aim items
   logic [63:0] pool_key   [POOL][KEY_WORDS];
   logic [31:0] pool_count [POOL];
   logic [63:0] pool_seen  [POOL];
   logic [63:0] clock_ms;
   bit          req_held;   // req_valid is still high from the item just accepted
   bit          calm;       // no idling on either side during this phase
   int          ready_left;
   int          quiet_cycles;

   nonce_replay_guard_table_top #(
      .SESSION_ENTRIES (SESSION_ENTRIES),
      .KEY_BYTES       (KEY_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_word0    (req_key_word0),
      .req_key_word1    (req_key_word1),
      .req_key_word2    (req_key_word2),
      .req_key_word3    (req_key_word3),
      .req_use_count    (req_use_count),
      .req_time_now     (req_time_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_table_full   (rsp_table_full),
      .rsp_reject_cause (rsp_reject_cause),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle lengths: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm)   return 0;
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver back-pressure, toggling between ready and stalled stretches
   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left = ready_left - 1;
      end else if (calm || !rsp_ready) begin
         rsp_ready <= 1'b1;
         ready_left = calm ? 0 : $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b0;
         ready_left = pick_gap();
      end
   end

   // handshake monitor: every accepted request feeds the model, every result is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.admit_request(req_key_word0, req_key_word1, req_key_word2,
                                req_key_word3, req_use_count, req_time_now);
         if (rsp_valid && rsp_ready)
            board.check_verdict(rsp_accepted, rsp_table_full, rsp_reject_cause);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // present one request item and return at the edge where it is taken;
   // valid stays high into the next item when no gap follows
   task automatic send_request(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                               logic [63:0] w3, logic [31:0] cnt, logic [63:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (req_held) req_valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_key_word0 <= w0;
      req_key_word1 <= w1;
      req_key_word2 <= w2;
      req_key_word3 <= w3;
      req_use_count <= cnt;
      req_time_now  <= now;
      do @(posedge clock); while (!req_ready);
      req_held = 1'b1;
   endtask

   // drop valid at the acceptance edge so the last item is not taken twice
   task automatic release_request();
      if (req_held) req_valid <= 1'b0;
      req_held = 1'b0;
   endtask

   task automatic wait_drained();
      release_request();
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // timeout is only rewritten with the block idle
   task automatic write_timeout(logic [31:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_timeout(value);
   endtask

   // mostly well-aimed traffic on pool nonces, the rest fresh or near-miss keys
   task automatic random_item(logic [31:0] tmo);
      logic [63:0] w [KEY_WORDS];
      logic [31:0] cnt;
      logic [31:0] step_cap;
      int          k;
      int          pick;
      int          r;
      k    = $urandom_range(0, POOL - 1);
      pick = $urandom_range(0, 99);
      for (int i = 0; i < KEY_WORDS; i++) w[i] = pool_key[k][i];
      if (pick >= 80 && pick < 90) begin
         for (int i = 0; i < KEY_WORDS; i++) w[i] = {$urandom, $urandom};
      end else if (pick >= 90) begin
         // one bit away from a known nonce
         r = $urandom_range(0, KEY_WORDS - 1);
         w[r][$urandom_range(0, 63)] ^= 1'b1;
      end

      // time: held, small step, right on the expiry boundary, past it, or anywhere
      r = $urandom_range(0, 99);
      step_cap = tmo >> 3;
      if (r < 45) begin
      end else if (r < 80) begin
         if (step_cap == 0) clock_ms += $urandom_range(0, 2);
         else clock_ms += $urandom_range(0, step_cap);
      end else if (r < 92) begin
         clock_ms = pool_seen[k] + {32'd0, tmo} + $urandom_range(0, 1);
      end else if (r < 97) begin
         clock_ms += {32'd0, tmo} + 64'd1 + $urandom_range(0, 1000);
      end else begin
         clock_ms = {$urandom, $urandom};
      end

      // count: fresh, equal, behind, or arbitrary
      r = $urandom_range(0, 99);
      if (r < 65)      cnt = pool_count[k] + $urandom_range(1, 4);
      else if (r < 80) cnt = pool_count[k];
      else if (r < 90) cnt = pool_count[k] - $urandom_range(1, 5);
      else             cnt = $urandom;

      if (pick < 80) begin
         pool_count[k] = cnt;
         pool_seen[k]  = clock_ms;
      end
      send_request(w[0], w[1], w[2], w[3], cnt, clock_ms);
   endtask

   initial begin
      logic [31:0] tmo_plan [7];
      logic [63:0] key_a [KEY_WORDS];
      int          words;

      board = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_key_word0 <= '0;
      req_key_word1 <= '0;
      req_key_word2 <= '0;
      req_key_word3 <= '0;
      req_use_count <= '0;
      req_time_now  <= '0;
      rsp_ready     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_wdata     <= '0;
      req_held     = 1'b0;
      calm         = 1'b0;
      ready_left   = 0;
      quiet_cycles = 0;

      // pool of nonces of mixed lengths, unused trailing words zero
      for (int k = 0; k < POOL; k++) begin
         words = $urandom_range(1, KEY_WORDS);
         for (int i = 0; i < KEY_WORDS; i++)
            pool_key[k][i] = (i < words) ? {$urandom, $urandom} : 64'd0;
         pool_count[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
         pool_seen[k]  = '0;
      end
      key_a[0] = 64'h0123_4567_89ab_cdef;
      key_a[1] = 64'hfedc_ba98_7654_3210;
      key_a[2] = 64'h0f1e_2d3c_4b5a_6978;
      key_a[3] = 64'd0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset timeout of 300000 ms
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'd5, 64'd1000);
      // equal count is a replay
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'd5, 64'd1000);
      // lower count is a replay
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'd4, 64'd1000);
      // elapsed exactly equal to the timeout is still live
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'd6, 64'd301000);
      // one past the timeout: session expired and removed
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'd7, 64'd601001);
      // same nonce again is now unknown and gets reinserted
      send_request(key_a[0], key_a[1], key_a[2], key_a[3], 32'hFFFF_FFFF, 64'd601001);
      // all-ones extremes for key, count and time
      send_request('1, '1, '1, '1, 32'hFFFF_FFFF, '1);
      // all-zero extremes, time wraps back to 0
      send_request('0, '0, '0, '0, 32'd0, 64'd0);
      // fill the table with distinct nonces at one time; the last ones find it full
      for (int i = 0; i < SESSION_ENTRIES; i++)
         send_request(64'(i + 1), ~64'(i), 64'd0, 64'd0, 32'(i), 64'd2000);
      // far enough on that every entry is swept before the insert
      send_request(64'h5a5a, 64'd0, 64'd0, 64'd0, 32'd1, 64'd302002);

      // timeout zero: same time is live, any later time expires
      write_timeout(32'd0);
      send_request(key_a[0], key_a[1], key_a[2], 64'd9, 32'd1, 64'd400000);
      send_request(key_a[0], key_a[1], key_a[2], 64'd9, 32'd2, 64'd400000);
      send_request(key_a[0], key_a[1], key_a[2], 64'd9, 32'd3, 64'd400001);

      // random phases over a spread of timeouts, extremes included
      tmo_plan[0] = 32'd0;
      tmo_plan[1] = 32'hFFFF_FFFF;
      tmo_plan[2] = 32'd1;
      tmo_plan[3] = TIMEOUT_RESET;
      tmo_plan[4] = $urandom;
      tmo_plan[5] = 32'd1000;
      tmo_plan[6] = $urandom_range(2, 50);
      for (int ph = 0; ph < 7; ph++) begin
         write_timeout(tmo_plan[ph]);
         calm = (ph == 3);
         // the widest timeout starts just short of the time wrap
         if (ph == 1) clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 32'h4000_0000);
         else clock_ms = {$urandom, $urandom};
         for (int k = 0; k < POOL; k++) pool_seen[k] = clock_ms;
         for (int n = 0; n < PHASE_ITEMS; n++) random_item(tmo_plan[ph]);
      end
      calm = 1'b0;

      wait_drained();
      repeat (SESSION_ENTRIES + 8) @(posedge clock);
      board.report_leftover();
      if (board.failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
